// File: sv/optc_pkg.sv
// package for the pose tracking controller: shared types, constants and helpers
// no dependencies; used by every other file of the block but optc_if
package optc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [19:0] ANG_PI = 20'sd205887;
	localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
	localparam logic signed [19:0] ANG_TWO_PI = 20'sd411775;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [17:0] GAIN_X_Q16 = 18'sd52429;

	typedef enum logic [2:0] {
		REG_GOAL_X = 3'd0,
		REG_GOAL_Y = 3'd1,
		REG_GOAL_HEADING = 3'd2,
		REG_DEADBAND_XY = 3'd3,
		REG_DEADBAND_HEADING = 3'd4,
		REG_SPEED_LIMIT = 3'd5,
		REG_MIN_SPEED_X = 3'd6,
		REG_MIN_SPEED_Y_TURN = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [24:0] goal_x;
		logic signed [24:0] goal_y;
		logic signed [18:0] goal_heading;
		logic [15:0] deadband_xy;
		logic [15:0] deadband_heading;
		logic [20:0] speed_limit;
		logic [20:0] min_speed_x;
		logic [20:0] min_speed_y_turn;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic signed [25:0] ex;
		logic signed [25:0] ey;
		logic signed [19:0] eh;
		logic signed [27:0] z0;
		logic neg;
		logic act_x;
		logic act_y;
		logic act_t;
	} front_item_t;

	typedef struct packed {
		logic signed [25:0] ex;
		logic signed [25:0] ey;
		logic signed [19:0] eh;
		logic neg;
		logic act_x;
		logic act_y;
		logic act_t;
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [27:0] z;
	} cordic_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [27:0] atan_entry(input int i);
		logic signed [27:0] r;
		case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			8: r = 28'sd65536;
			default: r = (i <= 24) ? 28'(64'sd1 <<< (24 - i)) : 28'sd0;
		endcase
		return r;
	endfunction

	// clamp to +-lim, then lift a nonzero magnitude below mn up to mn
	function automatic logic signed [31:0] shape(input logic signed [31:0] v,
			input logic [20:0] lim, input logic [20:0] mn);
		logic signed [31:0] l;
		logic signed [31:0] m;
		logic signed [31:0] r;
		l = signed'({11'd0, lim});
		m = signed'({11'd0, mn});
		r = v;
		if (r > l)
			r = l;
		else if (r < -l)
			r = -l;
		if (r > 0 && r < m)
			r = m;
		else if (r < 0 && -r < m)
			r = -m;
		return r;
	endfunction

endpackage

// File: sv/optc_if.sv
// channel interfaces of the pose tracking controller: pose in, velocity out, config writes
// depends on nothing but plain logic types
interface optc_pose_if;
	logic valid;
	logic ready;
	logic signed [24:0] pose_x;
	logic signed [24:0] pose_y;
	logic signed [18:0] pose_heading;
	modport source(output valid, pose_x, pose_y, pose_heading, input ready);
	modport sink(input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface optc_vel_if;
	logic valid;
	logic ready;
	logic signed [21:0] vel_x;
	logic signed [21:0] vel_y;
	logic signed [21:0] vel_turn;
	modport source(output valid, vel_x, vel_y, vel_turn, input ready);
	modport sink(input valid, vel_x, vel_y, vel_turn, output ready);
endinterface

interface optc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [24:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/optc_front.sv
// front part: config registers, pose errors, angle reduction and deadband classification
// depends on optc_pkg and the channel interfaces
module optc_front import optc_pkg::*; (
	input logic clk,
	input logic arst_n,
	optc_pose_if.sink pose,
	optc_cfg_if.sink cfg,
	input logic q_full,
	output logic push,
	output front_item_t item,
	output cfg_t cfg_regs
);
	cfg_t cfg_q;
	logic signed [19:0] a0;
	logic signed [19:0] a1;
	logic signed [19:0] a2;
	logic [24:0] abs_x;
	logic [24:0] abs_y;
	logic [19:0] abs_h;

	assign cfg.ready = 1'b1;
	assign cfg_regs = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x <= '0;
			cfg_q.goal_y <= '0;
			cfg_q.goal_heading <= '0;
			cfg_q.deadband_xy <= 16'd655;
			cfg_q.deadband_heading <= 16'd1144;
			cfg_q.speed_limit <= 21'd98304;
			cfg_q.min_speed_x <= 21'd6554;
			cfg_q.min_speed_y_turn <= 21'd655;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_GOAL_X: cfg_q.goal_x <= cfg.data;
				REG_GOAL_Y: cfg_q.goal_y <= cfg.data;
				REG_GOAL_HEADING: cfg_q.goal_heading <= cfg.data[18:0];
				REG_DEADBAND_XY: cfg_q.deadband_xy <= cfg.data[15:0];
				REG_DEADBAND_HEADING: cfg_q.deadband_heading <= cfg.data[15:0];
				REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg.data[20:0];
				REG_MIN_SPEED_X: cfg_q.min_speed_x <= cfg.data[20:0];
				REG_MIN_SPEED_Y_TURN: cfg_q.min_speed_y_turn <= cfg.data[20:0];
				default: ;
			endcase
		end
	end

	assign pose.ready = !q_full;
	assign push = pose.valid && !q_full;

	always_comb begin
		item.ex = 26'(cfg_q.goal_x) - 26'(pose.pose_x);
		item.ey = 26'(cfg_q.goal_y) - 26'(pose.pose_y);
		item.eh = 20'(cfg_q.goal_heading) - 20'(pose.pose_heading);
		// one wrap step covers the whole input range
		a0 = item.eh;
		if (a0 > ANG_PI)
			a1 = a0 - ANG_TWO_PI;
		else if (a0 < -ANG_PI)
			a1 = a0 + ANG_TWO_PI;
		else
			a1 = a0;
		item.neg = 1'b0;
		a2 = a1;
		if (a1 > ANG_HALF_PI) begin
			a2 = a1 - ANG_PI;
			item.neg = 1'b1;
		end else if (a1 < -ANG_HALF_PI) begin
			a2 = a1 + ANG_PI;
			item.neg = 1'b1;
		end
		item.z0 = 28'(a2) <<< 8;
		abs_x = 25'(item.ex < 0 ? -item.ex : item.ex);
		abs_y = 25'(item.ey < 0 ? -item.ey : item.ey);
		abs_h = 20'(item.eh < 0 ? -item.eh : item.eh);
		item.act_x = abs_x > {9'd0, cfg_q.deadband_xy};
		item.act_y = abs_y > {9'd0, cfg_q.deadband_xy};
		item.act_t = abs_h > {4'd0, cfg_q.deadband_heading};
	end
endmodule

// File: sv/optc_queue.sv
// short item queue between the front and the back parts
// depends on optc_pkg
module optc_queue import optc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input front_item_t wr_item,
	input logic pop,
	output front_item_t rd_item,
	output q_stat_t stat
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	front_item_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] cnt_q;

	assign stat.full = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign rd_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: sv/optc_back.sv
// back part: pipelined cordic, rotation products, gains, shaping and output register
// depends on optc_pkg and the channel interfaces
module optc_back import optc_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input front_item_t item,
	input logic avail,
	output logic pop,
	input cfg_t cfg_regs,
	optc_vel_if.source vel
);
	logic adv;
	logic out_v_q;
	cordic_t cs_q [CORDIC_STEPS+1];
	logic cv_q [CORDIC_STEPS+1];

	logic signed [31:0] c32;
	logic signed [31:0] s32;
	logic v_s1, v_s2, v_s3;
	logic signed [57:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [19:0] eh_s1, eh_s2, eh_s3;
	logic [2:0] act_s1, act_s2, act_s3;
	logic signed [58:0] sx;
	logic signed [58:0] sy;
	logic signed [28:0] rx_s2, ry_s2;
	logic signed [46:0] mx_s3;
	logic signed [31:0] vy_s3;
	logic signed [31:0] vx_c, vy_c, vt_c;

	// the whole back pipeline moves only when the output register can take
	assign adv = !out_v_q || vel.ready;
	assign pop = adv && avail;
	assign vel.valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_q[0] <= 1'b0;
		else if (adv)
			cv_q[0] <= avail;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_q[0].ex <= item.ex;
			cs_q[0].ey <= item.ey;
			cs_q[0].eh <= item.eh;
			cs_q[0].neg <= item.neg;
			cs_q[0].act_x <= item.act_x;
			cs_q[0].act_y <= item.act_y;
			cs_q[0].act_t <= item.act_t;
			cs_q[0].x <= CORDIC_GAIN_Q30;
			cs_q[0].y <= '0;
			cs_q[0].z <= item.z0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		cordic_t nxt;
		assign dx = cs_q[i].y >>> i;
		assign dy = cs_q[i].x >>> i;

		always_comb begin
			nxt = cs_q[i];
			if (!cs_q[i].z[27]) begin
				nxt.x = cs_q[i].x - dx;
				nxt.y = cs_q[i].y + dy;
				nxt.z = cs_q[i].z - atan_entry(i);
			end else begin
				nxt.x = cs_q[i].x + dx;
				nxt.y = cs_q[i].y - dy;
				nxt.z = cs_q[i].z + atan_entry(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_q[i+1] <= 1'b0;
			else if (adv)
				cv_q[i+1] <= cv_q[i];
		end

		always_ff @(posedge clk) begin
			if (adv)
				cs_q[i+1] <= nxt;
		end
	end

	// cos and sin in Q30, sign flipped when the angle was folded
	assign c32 = 32'(cs_q[CORDIC_STEPS].neg ? -cs_q[CORDIC_STEPS].x : cs_q[CORDIC_STEPS].x);
	assign s32 = 32'(cs_q[CORDIC_STEPS].neg ? -cs_q[CORDIC_STEPS].y : cs_q[CORDIC_STEPS].y);

	assign sx = 59'(pa_s1) - 59'(pb_s1) + 59'sd536870912;
	assign sy = 59'(pc_s1) + 59'(pd_s1) + 59'sd536870912;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= cv_q[CORDIC_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1 <= 58'(cs_q[CORDIC_STEPS].ex * c32);
			pb_s1 <= 58'(cs_q[CORDIC_STEPS].ey * s32);
			pc_s1 <= 58'(cs_q[CORDIC_STEPS].ex * s32);
			pd_s1 <= 58'(cs_q[CORDIC_STEPS].ey * c32);
			eh_s1 <= cs_q[CORDIC_STEPS].eh;
			act_s1 <= {cs_q[CORDIC_STEPS].act_x, cs_q[CORDIC_STEPS].act_y,
				cs_q[CORDIC_STEPS].act_t};

			rx_s2 <= 29'(sx >>> 30);
			ry_s2 <= 29'(sy >>> 30);
			eh_s2 <= eh_s1;
			act_s2 <= act_s1;

			mx_s3 <= 47'(rx_s2 * GAIN_X_Q16);
			vy_s3 <= 32'((32'(ry_s2) * 32'sd3 + 32'sd1) >>> 1);
			eh_s3 <= eh_s2;
			act_s3 <= act_s2;
		end
	end

	always_comb begin
		vx_c = act_s3[2] ? 32'((mx_s3 + 47'sd32768) >>> 16) : 32'sd0;
		vy_c = act_s3[1] ? vy_s3 : 32'sd0;
		vt_c = act_s3[0] ? (32'(eh_s3) <<< 1) : 32'sd0;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			vel.vel_x <= 22'(shape(vx_c, cfg_regs.speed_limit, cfg_regs.min_speed_x));
			vel.vel_y <= 22'(shape(vy_c, cfg_regs.speed_limit, cfg_regs.min_speed_y_turn));
			vel.vel_turn <= 22'(shape(vt_c, cfg_regs.speed_limit,
				cfg_regs.min_speed_y_turn));
		end
	end
endmodule

// File: sv/omni_pose_tracking_controller_core.sv
// Pose tracking controller: takes one pose item per cycle and returns one velocity item
// per pose. A pose passes the front and a four-item queue, then the back pipeline of
// CORDIC_STEPS cordic stages and four arithmetic stages; throughput is one item per
// cycle while the velocity side does not stall, set by the fully pipelined cordic and
// the four 26x32 multipliers. A stall on the velocity side freezes the back pipeline
// and the queue absorbs up to four poses before pose.ready drops. Config writes
// complete at once.
// depends on optc_pkg, optc_if, optc_front, optc_queue and optc_back
module omni_pose_tracking_controller_core import optc_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	optc_pose_if.sink pose,
	optc_cfg_if.sink cfg,
	optc_vel_if.source vel
);
	front_item_t f_item;
	front_item_t q_item;
	logic push;
	logic pop;
	q_stat_t q_stat;
	cfg_t cfg_regs;

	optc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose),
		.cfg(cfg),
		.q_full(q_stat.full),
		.push(push),
		.item(f_item),
		.cfg_regs(cfg_regs)
	);

	optc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(f_item),
		.pop(pop),
		.rd_item(q_item),
		.stat(q_stat)
	);

	optc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(q_item),
		.avail(!q_stat.empty),
		.pop(pop),
		.cfg_regs(cfg_regs),
		.vel(vel)
	);

`ifndef SYNTH
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("pop from empty queue");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		pose.ready == !q_stat.full)
		else $error("pose ready disagrees with queue fill");
`endif
endmodule

// File: tb/sv/omni_pose_tracking_controller_core_test.sv
// testbench for the pose tracking controller: drives poses and register writes, predicts
// velocities in its own fixed-point arithmetic and checks each velocity item in order
// depends on optc_pkg, optc_if and omni_pose_tracking_controller_core
`timescale 1ns / 100ps

module omni_pose_tracking_controller_core_test import optc_pkg::*; ();

	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 12;
	localparam int N_RANDOM = 720;

	typedef struct packed {
		logic signed [21:0] vx;
		logic signed [21:0] vy;
		logic signed [21:0] vt;
	} vel_item_t;

	typedef struct {
		logic signed [24:0] px;
		logic signed [24:0] py;
		logic signed [18:0] ph;
		bit known;
		vel_item_t want;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	optc_pose_if pose();
	optc_vel_if vel();
	optc_cfg_if cfg();

	omni_pose_tracking_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose.sink),
		.cfg(cfg.sink),
		.vel(vel.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	// local copy of the register file
	logic signed [24:0] goal_x, goal_y;
	logic signed [18:0] goal_h;
	logic [15:0] db_xy, db_h;
	logic [20:0] lim, min_x, min_yt;

	vel_item_t expected_vel[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int src_idle = 25;
	int snk_idle = 73;
	int hold_off = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q(longint v, int s);
		return floor_shift(v + (longint'(1) << (s - 1)), s);
	endfunction

	function automatic longint atan_q24(int i);
		case (i)
			0: return 13176795;
			1: return 7778716;
			2: return 4110060;
			3: return 2086331;
			4: return 1047214;
			5: return 524117;
			6: return 262123;
			7: return 131069;
			8: return 65536;
			default: return (i <= 24) ? (longint'(1) << (24 - i)) : 0;
		endcase
	endfunction

	function automatic longint limit_speed(longint v, longint l, longint m);
		if (v > l)
			v = l;
		else if (v < -l)
			v = -l;
		if (v > 0 && v < m)
			v = m;
		else if (v < 0 && -v < m)
			v = -m;
		return v;
	endfunction

	function automatic vel_item_t track_pose(logic signed [24:0] px, logic signed [24:0] py,
			logic signed [18:0] ph);
		longint ex, ey, eh, a, x, y, z, dx, dy, c, s, r, vx, vy, vt;
		bit flip;
		vel_item_t o;
		ex = longint'(goal_x) - longint'(px);
		ey = longint'(goal_y) - longint'(py);
		eh = longint'(goal_h) - longint'(ph);
		a = eh;
		flip = 0;
		while (a > 205887) a -= 411775;
		while (a < -205887) a += 411775;
		if (a > 102944) begin
			a -= 205887;
			flip = 1;
		end else if (a < -102944) begin
			a += 205887;
			flip = 1;
		end
		x = 652032874;
		y = 0;
		z = a * 256;
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_q24(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_q24(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		vx = 0;
		vy = 0;
		vt = 0;
		if ((ex < 0 ? -ex : ex) > longint'(db_xy)) begin
			r = round_q(ex * c - ey * s, 30);
			vx = round_q(r * 52429, 16);
		end
		if ((ey < 0 ? -ey : ey) > longint'(db_xy)) begin
			r = round_q(ex * s + ey * c, 30);
			vy = round_q(r * 3, 1);
		end
		if ((eh < 0 ? -eh : eh) > longint'(db_h))
			vt = eh * 2;
		o.vx = 22'(limit_speed(vx, lim, min_x));
		o.vy = 22'(limit_speed(vy, lim, min_yt));
		o.vt = 22'(limit_speed(vt, lim, min_yt));
		return o;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [24:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_GOAL_X: goal_x = value;
			REG_GOAL_Y: goal_y = value;
			REG_GOAL_HEADING: goal_h = value[18:0];
			REG_DEADBAND_XY: db_xy = value[15:0];
			REG_DEADBAND_HEADING: db_h = value[15:0];
			REG_SPEED_LIMIT: lim = value[20:0];
			REG_MIN_SPEED_X: min_x = value[20:0];
			REG_MIN_SPEED_Y_TURN: min_yt = value[20:0];
		endcase
		@(negedge clk);
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		while (expected_vel.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic send_pose(logic signed [24:0] px, logic signed [24:0] py,
			logic signed [18:0] ph);
		while ($urandom_range(99) < src_idle) begin
			pose.valid <= 1'b0;
			@(negedge clk);
		end
		pose.valid <= 1'b1;
		pose.pose_x <= px;
		pose.pose_y <= py;
		pose.pose_heading <= ph;
		do @(posedge clk); while (!pose.ready);
		expected_vel.push_back(track_pose(px, py, ph));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic stop_pose();
		pose.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [24:0] rand_pos();
		case ($urandom_range(3))
			0: return 25'($signed($urandom_range(131072)) - 65536);
			1: return $urandom_range(1) ? 25'sd16777215 : -25'sd16777215;
			default: return 25'($signed($urandom_range(33554430)) - 16777215);
		endcase
	endfunction

	function automatic logic signed [18:0] rand_head();
		return 19'($signed($urandom_range(411774)) - 205887);
	endfunction

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n)
			vel.ready <= 1'b0;
		else if (hold_off > 0) begin
			vel.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			vel.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		vel_item_t w;
		if (arst_n && vel.valid && vel.ready) begin
			if (expected_vel.size() == 0) begin
				$display("%0t: unexpected velocity %0d %0d %0d", $time, vel.vel_x,
					vel.vel_y, vel.vel_turn);
				errors++;
			end else begin
				w = expected_vel.pop_front();
				n_checked++;
				if (vel.vel_x !== w.vx) begin
					$display("%0t: vel_x expected %0d actual %0d", $time, w.vx, vel.vel_x);
					errors++;
				end
				if (vel.vel_y !== w.vy) begin
					$display("%0t: vel_y expected %0d actual %0d", $time, w.vy, vel.vel_y);
					errors++;
				end
				if (vel.vel_turn !== w.vt) begin
					$display("%0t: vel_turn expected %0d actual %0d", $time, w.vt,
						vel.vel_turn);
					errors++;
				end
			end
		end
	end

	pose_row_t rows[$];

	task automatic add_row(logic signed [24:0] px, logic signed [24:0] py,
			logic signed [18:0] ph, bit known = 0, int vx = 0, int vy = 0, int vt = 0);
		pose_row_t r;
		r.px = px;
		r.py = py;
		r.ph = ph;
		r.known = known;
		r.want.vx = 22'(vx);
		r.want.vy = 22'(vy);
		r.want.vt = 22'(vt);
		rows.push_back(r);
	endtask

	task automatic random_phase(int n, int mode);
		for (int k = 0; k < n; k++) begin
			if (mode == 1)
				// near the goal position: deadband, minimum speed and small position errors
				send_pose(goal_x + 25'($signed($urandom_range(4000)) - 2000),
					goal_y + 25'($signed($urandom_range(4000)) - 2000),
					19'($signed($urandom_range(4000)) - 2000));
			else
				send_pose(rand_pos(), rand_pos(), rand_head());
		end
		stop_pose();
	endtask

	initial begin
		vel_item_t got;
		pose.valid = 1'b0;
		pose.pose_x = '0;
		pose.pose_y = '0;
		pose.pose_heading = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_GOAL_X;
		cfg.data = '0;
		goal_x = 0;
		goal_y = 0;
		goal_h = 0;
		db_xy = 655;
		db_h = 1144;
		lim = 98304;
		min_x = 6554;
		min_yt = 655;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: with reset registers a pose at the goal gives zero
		add_row(0, 0, 0, 1, 0, 0, 0);
		add_row(655, -655, 1144, 1, 0, 0, 0);
		add_row(-25'sd16777215, 0, 0, 1, 98304, 0, 0);
		add_row(25'sd16777215, 0, 0, 1, -98304, 0, 0);
		add_row(0, -25'sd16777215, 0, 1, 0, 98304, 0);
		add_row(0, 0, -19'sd205887);
		add_row(0, 0, 19'sd205887);
		add_row(0, 0, -1145, 1, 0, 0, 2290);
		add_row(0, 0, 1145, 1, 0, 0, -2290);
		add_row(-656, 0, 0);
		add_row(0, 656, 0);
		add_row(-65536, -65536, 19'sd102944);
		add_row(65536, 65536, -19'sd102945);
		add_row(25'sd16777215, -25'sd16777215, 19'sd205887);
		foreach (rows[i]) begin
			if (rows[i].known) begin
				got = track_pose(rows[i].px, rows[i].py, rows[i].ph);
				if (got != rows[i].want) begin
					$display("%0t: row %0d predicted %0d %0d %0d expected %0d %0d %0d", $time,
						i, got.vx, got.vy, got.vt, rows[i].want.vx, rows[i].want.vy,
						rows[i].want.vt);
					errors++;
				end
			end
			send_pose(rows[i].px, rows[i].py, rows[i].ph);
		end
		stop_pose();
		drain();

		// goal far away, heading error wraps beyond pi, minimum equal to limit
		write_reg(REG_GOAL_X, 25'h0FFFFFF);
		write_reg(REG_GOAL_Y, 25'h1000001);
		write_reg(REG_GOAL_HEADING, 25'(19'sd205887));
		write_reg(REG_DEADBAND_XY, 25'(16'hFFFF));
		write_reg(REG_DEADBAND_HEADING, 25'(16'd0));
		write_reg(REG_SPEED_LIMIT, 25'(21'd1048576));
		write_reg(REG_MIN_SPEED_X, 25'(21'd1048576));
		write_reg(REG_MIN_SPEED_Y_TURN, 25'(21'd0));
		for (int k = 0; k < 6; k++) send_pose(rand_pos(), rand_pos(), rand_head());
		send_pose(0, 0, -19'sd205887);
		stop_pose();
		drain();

		write_reg(REG_GOAL_HEADING, 25'(-19'sd205887));
		write_reg(REG_DEADBAND_XY, 25'(16'd0));
		write_reg(REG_SPEED_LIMIT, 25'(21'd0));
		write_reg(REG_MIN_SPEED_X, 25'(21'd0));
		write_reg(REG_MIN_SPEED_Y_TURN, 25'(21'd1048576));
		for (int k = 0; k < 5; k++) send_pose(rand_pos(), rand_pos(), rand_head());
		stop_pose();
		drain();

		// back-pressure: receiver holds off while poses keep coming
		src_idle = 0;
		hold_off = 60;
		random_phase(40, 0);
		drain();

		src_idle = 25;
		snk_idle = 73;
		write_reg(REG_GOAL_X, 25'(rand_pos()));
		write_reg(REG_GOAL_Y, 25'(rand_pos()));
		write_reg(REG_GOAL_HEADING, 25'(rand_head()));
		write_reg(REG_DEADBAND_XY, 25'(16'd655));
		write_reg(REG_DEADBAND_HEADING, 25'(16'd1144));
		write_reg(REG_SPEED_LIMIT, 25'(21'd98304));
		write_reg(REG_MIN_SPEED_X, 25'(21'd6554));
		write_reg(REG_MIN_SPEED_Y_TURN, 25'(21'd655));
		random_phase(N_RANDOM / 6, 0);
		random_phase(N_RANDOM / 6, 1);
		drain();

		src_idle = 73;
		snk_idle = 25;
		write_reg(REG_SPEED_LIMIT, 25'($urandom_range(1048576)));
		write_reg(REG_DEADBAND_XY, 25'($urandom_range(65535)));
		write_reg(REG_MIN_SPEED_X, 25'($urandom_range(20000)));
		write_reg(REG_MIN_SPEED_Y_TURN, 25'($urandom_range(20000)));
		random_phase(N_RANDOM / 6, 0);
		random_phase(N_RANDOM / 6, 1);
		drain();

		src_idle = 0;
		snk_idle = 0;
		write_reg(REG_DEADBAND_HEADING, 25'($urandom_range(65535)));
		write_reg(REG_GOAL_X, 25'(rand_pos()));
		random_phase(N_RANDOM / 6, 0);
		random_phase(N_RANDOM / 6, 1);
		drain();

		$display("covered %0d poses, %0d velocities checked, over several register settings",
			n_sent, n_checked);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
